### rtl/nod_pkg.sv
package nod_pkg;

    localparam int NOTE_W       = 7;
    localparam int VEL_W        = 7;
    localparam int STEP_W       = 24;
    localparam int NOTE_SLOTS_DEF = 128;

    // per-note memory word: open flag above the open velocity
    localparam int ENTRY_W      = VEL_W + 1;

    // output queue
    localparam int OUTQ_DEPTH   = 8;
    localparam int OUTQ_PTR_W   = 3;
    localparam int OUTQ_CNT_W   = 4;

    // configuration port
    localparam int PADDR_W      = 4;
    localparam int PDATA_W      = 32;
    localparam logic [VEL_W-1:0] OFF_VELOCITY_RST = 7'd64;

    typedef enum logic [1:0] {
        EV_OFF   = 2'd0,
        EV_ON    = 2'd1,
        EV_RAISE = 2'd2
    } event_kind_t;

    typedef enum logic [1:0] {
        REG_ON_THRESHOLD   = 2'd0,
        REG_OFF_THRESHOLD  = 2'd1,
        REG_PEAK_THRESHOLD = 2'd2,
        REG_OFF_VELOCITY   = 2'd3
    } reg_index_t;

    typedef struct packed {
        event_kind_t         kind;
        logic [NOTE_W-1:0]   note;
        logic [VEL_W-1:0]    velocity;
        logic [STEP_W-1:0]   step;
        logic                last;
    } event_t;

endpackage

### rtl/nod_ram.sv
module nod_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/note_onoff_detector_core.sv
// path: an accepted transaction is registered into stage 1, which decides its results
//   and writes them into the output queue; the queue head drives the result channel
// throughput: one input transaction per cycle while the output queue has room; one result
//   leaves per cycle, so an input that yields two results can hold the input side back under load
// reset: rst_n clears every note to closed (per-note valid flops), empties the pipeline
//   and output queue, and loads the register defaults; no clearing pass is needed
module note_onoff_detector_core #(
    parameter int NOTE_SLOTS = nod_pkg::NOTE_SLOTS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // input channel
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [nod_pkg::NOTE_W-1:0]      note_number,
    input  logic [nod_pkg::VEL_W-1:0]       level,
    input  logic [nod_pkg::STEP_W-1:0]      step_index,
    // result channel
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [1:0]                      event_kind,
    output logic [nod_pkg::NOTE_W-1:0]      note_out,
    output logic [nod_pkg::VEL_W-1:0]       velocity_out,
    output logic [nod_pkg::STEP_W-1:0]      step_out,
    output logic                            last_of_run,
    // configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [nod_pkg::PADDR_W-1:0]     paddr,
    input  logic [nod_pkg::PDATA_W-1:0]     pwdata,
    output logic [nod_pkg::PDATA_W-1:0]     prdata,
    output logic                            pready
);

    localparam int ADDR_W = (NOTE_SLOTS > 1) ? $clog2(NOTE_SLOTS) : 1;
    localparam int VW     = nod_pkg::VEL_W;
    localparam int EW     = nod_pkg::ENTRY_W;

    // ---------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------
    logic [VW-1:0] on_thr_reg,   on_thr_next;
    logic [VW-1:0] off_thr_reg,  off_thr_next;
    logic [VW-1:0] peak_thr_reg, peak_thr_next;
    logic [VW-1:0] off_vel_reg,  off_vel_next;
    logic          cfg_wr;
    nod_pkg::reg_index_t cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_idx = nod_pkg::reg_index_t'(paddr[3:2]);

    always_comb
    begin
        on_thr_next   = on_thr_reg;
        off_thr_next  = off_thr_reg;
        peak_thr_next = peak_thr_reg;
        off_vel_next  = off_vel_reg;
        if (cfg_wr)
        begin
            case (cfg_idx)
                nod_pkg::REG_ON_THRESHOLD:   on_thr_next   = pwdata[VW-1:0];
                nod_pkg::REG_OFF_THRESHOLD:  off_thr_next  = pwdata[VW-1:0];
                nod_pkg::REG_PEAK_THRESHOLD: peak_thr_next = pwdata[VW-1:0];
                nod_pkg::REG_OFF_VELOCITY:   off_vel_next  = pwdata[VW-1:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        case (cfg_idx)
            nod_pkg::REG_ON_THRESHOLD:   prdata = nod_pkg::PDATA_W'(on_thr_reg);
            nod_pkg::REG_OFF_THRESHOLD:  prdata = nod_pkg::PDATA_W'(off_thr_reg);
            nod_pkg::REG_PEAK_THRESHOLD: prdata = nod_pkg::PDATA_W'(peak_thr_reg);
            nod_pkg::REG_OFF_VELOCITY:   prdata = nod_pkg::PDATA_W'(off_vel_reg);
            default:                     prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            on_thr_reg   <= '0;
            off_thr_reg  <= '0;
            peak_thr_reg <= '0;
            off_vel_reg  <= nod_pkg::OFF_VELOCITY_RST;
        end
        else
        begin
            on_thr_reg   <= on_thr_next;
            off_thr_reg  <= off_thr_next;
            peak_thr_reg <= peak_thr_next;
            off_vel_reg  <= off_vel_next;
        end
    end

    // ---------------------------------------------------------------
    // stage 0: accept transaction, issue the per-note memory read
    // ---------------------------------------------------------------
    logic              in_fire;
    logic              in_hit;      // note lies inside the slot range
    logic [ADDR_W-1:0] in_addr;

    assign in_fire = in_valid & in_ready;
    assign in_hit  = ({1'b0, note_number} < (nod_pkg::NOTE_W + 1)'(NOTE_SLOTS));
    assign in_addr = note_number[ADDR_W-1:0];

    // stage 1 registers
    logic                      s1_valid_reg, s1_valid_next;
    logic [ADDR_W-1:0]         s1_addr_reg;
    logic [nod_pkg::NOTE_W-1:0] s1_note_reg;
    logic [VW-1:0]             s1_level_reg;
    logic [nod_pkg::STEP_W-1:0] s1_step_reg;
    logic                      s1_vld_reg;    // entry has been written since reset
    logic                      fwd_hit_reg;   // entry was written at the read edge
    logic [EW-1:0]             fwd_data_reg;

    // per-note valid flops: an entry never written reads as closed
    logic [NOTE_SLOTS-1:0]     vld_reg, vld_next;

    // memory write from stage 1
    logic              wr_en;
    logic [EW-1:0]     wr_data;
    logic [EW-1:0]     ram_rdata;

    nod_ram #(
        .WIDTH (EW),
        .DEPTH (NOTE_SLOTS)
    ) u_note_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (s1_addr_reg),
        .wdata (wr_data),
        .re    (in_fire),
        .raddr (in_addr),
        .rdata (ram_rdata)
    );

    assign s1_valid_next = in_fire & in_hit;

    always_comb
    begin
        vld_next = vld_reg;
        if (wr_en)
        begin
            vld_next[s1_addr_reg] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            vld_reg      <= '0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            vld_reg      <= vld_next;
        end
    end

    // stage 1 payload, including forwarding from the write at the read edge
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_addr_reg  <= in_addr;
            s1_note_reg  <= note_number;
            s1_level_reg <= level;
            s1_step_reg  <= step_index;
            s1_vld_reg   <= vld_reg[in_addr];
            fwd_hit_reg  <= wr_en && (s1_addr_reg == in_addr);
            fwd_data_reg <= wr_data;
        end
    end

    // ---------------------------------------------------------------
    // stage 1: decide events, write the entry back, push results
    // ---------------------------------------------------------------
    logic [EW-1:0]  entry;
    logic           cur_open;
    logic [VW-1:0]  held;
    logic [VW:0]    peak_sum;   // one bit wider so the bound never wraps
    logic [1:0]     push_n;
    nod_pkg::event_t ev0, ev1;

    assign entry    = fwd_hit_reg ? fwd_data_reg : (s1_vld_reg ? ram_rdata : '0);
    assign cur_open = entry[EW-1];
    assign held     = entry[VW-1:0];
    assign peak_sum = {1'b0, held} + {1'b0, peak_thr_reg};

    always_comb
    begin
        wr_en        = 1'b0;
        wr_data      = entry;
        push_n       = 2'd0;
        ev0.kind     = nod_pkg::EV_OFF;
        ev0.note     = s1_note_reg;
        ev0.velocity = off_vel_reg;
        ev0.step     = s1_step_reg;
        ev0.last     = 1'b1;
        ev1.kind     = nod_pkg::EV_ON;
        ev1.note     = s1_note_reg;
        ev1.velocity = s1_level_reg;
        ev1.step     = s1_step_reg;
        ev1.last     = 1'b1;
        if (s1_valid_reg)
        begin
            if (!cur_open)
            begin
                // closed note opens above the on threshold
                if (s1_level_reg > on_thr_reg)
                begin
                    wr_en        = 1'b1;
                    wr_data      = {1'b1, s1_level_reg};
                    push_n       = 2'd1;
                    ev0.kind     = nod_pkg::EV_ON;
                    ev0.velocity = s1_level_reg;
                end
            end
            else if (s1_level_reg <= off_thr_reg)
            begin
                // open note falls to the off threshold
                wr_en   = 1'b1;
                wr_data = {1'b0, held};
                push_n  = 2'd1;
            end
            else if ({1'b0, s1_level_reg} >= peak_sum)
            begin
                // retrigger: off first, then on
                wr_en    = 1'b1;
                wr_data  = {1'b1, s1_level_reg};
                push_n   = 2'd2;
                ev0.last = 1'b0;
            end
            else if (s1_level_reg > held)
            begin
                wr_en        = 1'b1;
                wr_data      = {1'b1, s1_level_reg};
                push_n       = 2'd1;
                ev0.kind     = nod_pkg::EV_RAISE;
                ev0.velocity = s1_level_reg;
            end
        end
    end

    // ---------------------------------------------------------------
    // output queue: decouples the pipeline from result backpressure
    // ---------------------------------------------------------------
    nod_pkg::event_t outq_reg [nod_pkg::OUTQ_DEPTH];
    logic [nod_pkg::OUTQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [nod_pkg::OUTQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [nod_pkg::OUTQ_CNT_W-1:0] cnt_reg, cnt_next;
    logic [nod_pkg::OUTQ_CNT_W-1:0] reserved;
    logic [nod_pkg::OUTQ_PTR_W-1:0] wr_ptr_p1;
    logic                           pop;
    nod_pkg::event_t                head;

    // room for the results of the item in stage 1 and of a new one
    assign reserved = cnt_reg + {{(nod_pkg::OUTQ_CNT_W-2){1'b0}}, s1_valid_reg, 1'b0};
    assign in_ready = (reserved <= nod_pkg::OUTQ_CNT_W'(nod_pkg::OUTQ_DEPTH - 2));

    assign head      = outq_reg[rd_ptr_reg];
    assign out_valid = (cnt_reg != '0);
    assign pop       = out_valid & out_ready;
    assign wr_ptr_p1 = wr_ptr_reg + 1'b1;

    assign event_kind   = head.kind;
    assign note_out     = head.note;
    assign velocity_out = head.velocity;
    assign step_out     = head.step;
    assign last_of_run  = head.last;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + nod_pkg::OUTQ_PTR_W'(push_n);
        rd_ptr_next = rd_ptr_reg + nod_pkg::OUTQ_PTR_W'(pop);
        cnt_next    = cnt_reg + nod_pkg::OUTQ_CNT_W'(push_n)
                      - nod_pkg::OUTQ_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
        begin
            outq_reg[wr_ptr_reg] <= ev0;
        end
        if (push_n == 2'd2)
        begin
            outq_reg[wr_ptr_p1] <= ev1;
        end
    end

endmodule

### tb/note_onoff_detector_core_tb.sv
`timescale 1ns / 1ps

module note_onoff_detector_core_tb;

    localparam int SLOTS         = nod_pkg::NOTE_SLOTS_DEF;
    localparam int LEVEL_MAX     = (1 << nod_pkg::VEL_W) - 1;
    localparam int SETTLE_CYCLES = 8;        // well past the pipeline latency
    localparam int CYCLE_LIMIT   = 600000;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 155;
    localparam int POOL_SIZE     = 6;
    localparam int REPORT_LIMIT  = 40;

    // receiver behaviors, switched after a random hold
    typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_PATTERN, RX_CHOKED} rx_mode_t;

    // per-note open/held-velocity tracking and the queue of events still owed
    class note_event_tracker;
        logic                      is_open  [SLOTS];
        logic [nod_pkg::VEL_W-1:0] held_vel [SLOTS];
        logic [nod_pkg::VEL_W-1:0] on_thr, off_thr, peak_thr, off_vel;
        nod_pkg::event_t           pending[$];
        int                        errors, reports, levels_taken, retriggers;
        int                        kinds_seen [3];

        function new();
            foreach (is_open[i])
            begin
                is_open[i]  = 1'b0;
                held_vel[i] = '0;
            end
            on_thr   = '0;
            off_thr  = '0;
            peak_thr = '0;
            off_vel  = nod_pkg::OFF_VELOCITY_RST;
        endfunction

        function void write_reg(nod_pkg::reg_index_t idx, logic [nod_pkg::VEL_W-1:0] val);
            case (idx)
                nod_pkg::REG_ON_THRESHOLD:   on_thr   = val;
                nod_pkg::REG_OFF_THRESHOLD:  off_thr  = val;
                nod_pkg::REG_PEAK_THRESHOLD: peak_thr = val;
                nod_pkg::REG_OFF_VELOCITY:   off_vel  = val;
                default: ;
            endcase
        endfunction

        function void log_error(string msg);
            errors++;
            if (reports < REPORT_LIMIT)
                $display("%s", msg);
            else if (reports == REPORT_LIMIT)
                $display("further mismatch reports suppressed");
            reports++;
        endfunction

        function void field_mismatch(string what, logic [31:0] want, logic [31:0] got);
            log_error($sformatf("%0t  %s mismatch: expected %0d, got %0d",
                                $time, what, want, got));
        endfunction

        function void queue_event(nod_pkg::event_kind_t kind,
                                  logic [nod_pkg::NOTE_W-1:0] note,
                                  logic [nod_pkg::VEL_W-1:0] vel,
                                  logic [nod_pkg::STEP_W-1:0] step, logic last);
            pending.push_back(nod_pkg::event_t'{kind: kind, note: note, velocity: vel,
                                                step: step, last: last});
        endfunction

        function void take_level(logic [nod_pkg::NOTE_W-1:0] note,
                                 logic [nod_pkg::VEL_W-1:0] lvl,
                                 logic [nod_pkg::STEP_W-1:0] step);
            logic [nod_pkg::VEL_W:0] bound;
            levels_taken++;
            if (note >= SLOTS)
                return;
            if (!is_open[note])
            begin
                if (lvl > on_thr)
                begin
                    is_open[note]  = 1'b1;
                    held_vel[note] = lvl;
                    queue_event(nod_pkg::EV_ON, note, lvl, step, 1'b1);
                end
                return;
            end
            if (lvl <= off_thr)
            begin
                is_open[note] = 1'b0;
                queue_event(nod_pkg::EV_OFF, note, off_vel, step, 1'b1);
                return;
            end
            // sum at one bit wider so a large peak threshold never wraps
            bound = {1'b0, held_vel[note]} + {1'b0, peak_thr};
            if ({1'b0, lvl} >= bound)
            begin
                held_vel[note] = lvl;
                queue_event(nod_pkg::EV_OFF, note, off_vel, step, 1'b0);
                queue_event(nod_pkg::EV_ON, note, lvl, step, 1'b1);
                retriggers++;
            end
            else if (lvl > held_vel[note])
            begin
                held_vel[note] = lvl;
                queue_event(nod_pkg::EV_RAISE, note, lvl, step, 1'b1);
            end
        endfunction

        function void match_event(logic [1:0] kind, logic [nod_pkg::NOTE_W-1:0] note,
                                  logic [nod_pkg::VEL_W-1:0] vel,
                                  logic [nod_pkg::STEP_W-1:0] step, logic last);
            nod_pkg::event_t exp_ev;
            if (pending.size() == 0)
            begin
                log_error($sformatf({"%0t  result with none pending: expected nothing, ",
                                     "got kind %0d note %0d vel %0d step %0d last %0d"},
                                    $time, kind, note, vel, step, last));
                return;
            end
            exp_ev = pending.pop_front();
            if (kind !== exp_ev.kind)
                field_mismatch("event_kind", 32'(exp_ev.kind), 32'(kind));
            if (note !== exp_ev.note)
                field_mismatch("note_out", 32'(exp_ev.note), 32'(note));
            if (vel !== exp_ev.velocity)
                field_mismatch("velocity_out", 32'(exp_ev.velocity), 32'(vel));
            if (step !== exp_ev.step)
                field_mismatch("step_out", 32'(exp_ev.step), 32'(step));
            if (last !== exp_ev.last)
                field_mismatch("last_of_run", 32'(exp_ev.last), 32'(last));
            kinds_seen[exp_ev.kind]++;
        endfunction
    endclass

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // level input channel
    logic                       in_valid    = 1'b0;
    logic                       in_ready;
    logic [nod_pkg::NOTE_W-1:0] note_number = '0;
    logic [nod_pkg::VEL_W-1:0]  level       = '0;
    logic [nod_pkg::STEP_W-1:0] step_index  = '0;

    // event output channel
    logic                       out_valid;
    logic                       out_ready   = 1'b0;
    logic [1:0]                 event_kind;
    logic [nod_pkg::NOTE_W-1:0] note_out;
    logic [nod_pkg::VEL_W-1:0]  velocity_out;
    logic [nod_pkg::STEP_W-1:0] step_out;
    logic                       last_of_run;

    // register port
    logic                        psel    = 1'b0;
    logic                        penable = 1'b0;
    logic                        pwrite  = 1'b0;
    logic [nod_pkg::PADDR_W-1:0] paddr   = '0;
    logic [nod_pkg::PDATA_W-1:0] pwdata  = '0;
    logic [nod_pkg::PDATA_W-1:0] prdata;
    logic                        pready;

    note_event_tracker          tracker;
    logic [nod_pkg::NOTE_W-1:0] note_pool [POOL_SIZE];
    logic [nod_pkg::STEP_W-1:0] step_ctr;
    int                         settings_used;
    int unsigned                cycle_count = 0;

    // receiver pattern state
    rx_mode_t    rx_mode   = RX_OPEN;
    int unsigned mode_left = 0;
    logic [3:0]  rx_phase  = '0;

    always #2 clk = ~clk;

    note_onoff_detector_core #(
        .NOTE_SLOTS (SLOTS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .note_number  (note_number),
        .level        (level),
        .step_index   (step_index),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .event_kind   (event_kind),
        .note_out     (note_out),
        .velocity_out (velocity_out),
        .step_out     (step_out),
        .last_of_run  (last_of_run),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // hard stop in case a result never shows up
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d events still pending",
                     cycle_count, tracker.pending.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // receiver: open, random, a fixed pattern from a 4-bit phase counter, or mostly stalled
    always @(posedge clk)
    begin
        if (mode_left == 0)
        begin
            rx_mode   <= rx_mode_t'($urandom_range(0, 3));
            mode_left <= $urandom_range(64, 400);
        end
        else
            mode_left <= mode_left - 1;
        rx_phase <= rx_phase + 1'b1;
        case (rx_mode)
            RX_OPEN:    out_ready <= 1'b1;
            RX_RANDOM:  out_ready <= ($urandom_range(0, 3) != 0);
            RX_PATTERN: out_ready <= (rx_phase < 4'd5);
            default:    out_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // every event transaction is checked against the oldest one owed
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            tracker.match_event(event_kind, note_out, velocity_out, step_out, last_of_run);
    end

    // one level transaction; prediction happens at the accepting edge
    task automatic send_level(input logic [nod_pkg::NOTE_W-1:0] n,
                              input logic [nod_pkg::VEL_W-1:0] l,
                              input logic [nod_pkg::STEP_W-1:0] s);
        in_valid    <= 1'b1;
        note_number <= n;
        level       <= l;
        step_index  <= s;
        do @(posedge clk); while (!in_ready);
        tracker.take_level(n, l, s);
    endtask

    task automatic idle_input(input int cycles);
        if (cycles == 0)
            return;
        in_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // hold the sender until every owed event has come back
    task automatic pause_until_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (tracker.pending.size() != 0);
    endtask

    task automatic apb_write(input nod_pkg::reg_index_t idx,
                             input logic [nod_pkg::VEL_W-1:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= nod_pkg::PADDR_W'({idx, 2'b00});
        pwdata  <= nod_pkg::PDATA_W'(val);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        tracker.write_reg(idx, val);
    endtask

    task automatic apb_read_check(input nod_pkg::reg_index_t idx,
                                  input logic [nod_pkg::VEL_W-1:0] want);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= nod_pkg::PADDR_W'({idx, 2'b00});
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata[nod_pkg::VEL_W-1:0] !== want)
            tracker.field_mismatch(idx.name(), 32'(want), 32'(prdata[nod_pkg::VEL_W-1:0]));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic read_back_all();
        apb_read_check(nod_pkg::REG_ON_THRESHOLD, tracker.on_thr);
        apb_read_check(nod_pkg::REG_OFF_THRESHOLD, tracker.off_thr);
        apb_read_check(nod_pkg::REG_PEAK_THRESHOLD, tracker.peak_thr);
        apb_read_check(nod_pkg::REG_OFF_VELOCITY, tracker.off_vel);
    endtask

    // registers only change with the block idle: drained plus a latency margin,
    // since a level with no event may still be in flight
    task automatic apply_settings(input logic [nod_pkg::VEL_W-1:0] on_v,
                                  input logic [nod_pkg::VEL_W-1:0] off_v,
                                  input logic [nod_pkg::VEL_W-1:0] peak_v,
                                  input logic [nod_pkg::VEL_W-1:0] ov_v);
        pause_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        apb_write(nod_pkg::REG_ON_THRESHOLD, on_v);
        apb_write(nod_pkg::REG_OFF_THRESHOLD, off_v);
        apb_write(nod_pkg::REG_PEAK_THRESHOLD, peak_v);
        apb_write(nod_pkg::REG_OFF_VELOCITY, ov_v);
        read_back_all();
        settings_used++;
    endtask

    // levels aimed at the interesting bands: closing, near the held value
    // (raise vs retrigger), just above the on threshold, or anywhere
    function automatic logic [nod_pkg::VEL_W-1:0] pick_level(
        input logic [nod_pkg::NOTE_W-1:0] n);
        int base;
        int v;
        case ($urandom_range(0, 9))
            0, 1: v = $urandom_range(0, tracker.off_thr);
            2, 3, 4:
            begin
                base = tracker.is_open[n] ? tracker.held_vel[n] : tracker.on_thr;
                v = base + $urandom_range(0, tracker.peak_thr + 1);
            end
            5, 6: v = (tracker.on_thr < LEVEL_MAX)
                      ? $urandom_range(tracker.on_thr + 1, LEVEL_MAX) : LEVEL_MAX;
            default: v = $urandom_range(0, LEVEL_MAX);
        endcase
        if (v > LEVEL_MAX)
            v = LEVEL_MAX;
        return v[nod_pkg::VEL_W-1:0];
    endfunction

    // hand-picked sequences around each threshold, with extreme notes and steps
    task automatic directed_levels();
        apply_settings(7'd20, 7'd10, 7'd30, 7'd127);
        send_level(7'd0,   7'd0,   24'd0);          // closed, level zero: nothing
        send_level(7'd0,   7'd20,  24'd1);          // equal to on threshold: nothing
        send_level(7'd0,   7'd21,  24'd2);          // opens
        send_level(7'd0,   7'd21,  24'd3);          // quiet open note
        send_level(7'd0,   7'd40,  24'd4);          // raise
        send_level(7'd0,   7'd70,  24'd5);          // retrigger, off then on
        send_level(7'd0,   7'd11,  24'd6);          // quiet again
        send_level(7'd0,   7'd10,  24'd7);          // at off threshold: closes
        send_level(7'd127, 7'd127, 24'hFFFFFF);     // top note opens at top level
        send_level(7'd127, 7'd127, 24'hFFFFFE);     // peak bound above 127, no wrap
        send_level(7'd127, 7'd0,   24'h555555);     // closes
        send_level(7'd64,  7'd21,  24'hAAAAAA);     // opens
        send_level(7'd64,  7'd51,  24'h123456);     // exactly held plus peak: retrigger
        send_level(7'd64,  7'd50,  24'hFEDCBA);     // below new held: quiet

        // zero thresholds: equal level retriggers
        apply_settings(7'd0, 7'd0, 7'd0, 7'd0);
        send_level(7'd1,   7'd1,   24'd0);
        send_level(7'd1,   7'd1,   24'd1);
        send_level(7'd1,   7'd0,   24'd2);
        send_level(7'd1,   7'd0,   24'd3);          // closed note at level zero
        send_level(7'd127, 7'd127, 24'hFFFFFF);
        send_level(7'd127, 7'd127, 24'd0);
        send_level(7'd127, 7'd126, 24'd1);
        send_level(7'd127, 7'd0,   24'd2);
    endtask

    task automatic run_phase(input int count, input bit bursty);
        int                         burst_left;
        logic [nod_pkg::NOTE_W-1:0] n;
        burst_left = 0;
        for (int i = 0; i < count; i++)
        begin
            if (burst_left == 0)
            begin
                if (bursty)
                    idle_input($urandom_range(0, 6));
                burst_left = $urandom_range(1, 24);
            end
            burst_left--;
            // sender holds off until the event queue is empty
            if (i == count / 2 || $urandom_range(0, 199) == 0)
                pause_until_drained();
            // a few notes carry most of the traffic so sequences build up
            if ($urandom_range(0, 99) < 85)
                n = note_pool[$urandom_range(0, POOL_SIZE - 1)];
            else
                n = nod_pkg::NOTE_W'($urandom_range(0, SLOTS - 1));
            if ($urandom_range(0, 15) == 0)
                step_ctr = nod_pkg::STEP_W'($urandom());
            send_level(n, pick_level(n), step_ctr);
            step_ctr = step_ctr + 1'b1;
        end
    endtask

    initial
    begin
        logic [nod_pkg::VEL_W-1:0] s_on, s_off, s_peak, s_ov;
        tracker       = new();
        settings_used = 0;
        step_ctr      = nod_pkg::STEP_W'($urandom());
        foreach (note_pool[k])
            note_pool[k] = nod_pkg::NOTE_W'($urandom_range(0, SLOTS - 1));

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // registers must come up at their defaults
        read_back_all();
        directed_levels();

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: {s_on, s_off, s_peak, s_ov} = {7'd0, 7'd0, 7'd0, 7'd0};
                1: {s_on, s_off, s_peak, s_ov} = {7'd127, 7'd127, 7'd127, 7'd127};
                2: {s_on, s_off, s_peak, s_ov} = {7'd40, 7'd20, 7'd15, 7'd90};
                3: {s_on, s_off, s_peak, s_ov} = {7'd10, 7'd60, 7'd5, 7'd33};
                4: {s_on, s_off, s_peak, s_ov} = {7'd0, 7'd0, 7'd127, 7'd127};
                default:
                begin
                    s_on   = nod_pkg::VEL_W'($urandom_range(0, 100));
                    s_off  = nod_pkg::VEL_W'($urandom_range(0, s_on));
                    s_peak = nod_pkg::VEL_W'($urandom_range(0, 40));
                    s_ov   = nod_pkg::VEL_W'($urandom_range(0, LEVEL_MAX));
                end
            endcase
            apply_settings(s_on, s_off, s_peak, s_ov);
            // swap part of the note pool; kept notes carry their state over
            foreach (note_pool[k])
                if ($urandom_range(0, 1) == 0)
                    note_pool[k] = nod_pkg::NOTE_W'($urandom_range(0, SLOTS - 1));
            // this phase also runs the step counter through its wrap
            if (p == 3)
                step_ctr = 24'hFFFFF0;
            run_phase(PHASE_ITEMS, (p % 3) != 1);
        end

        pause_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("run covered %0d level transactions under %0d register settings",
                 tracker.levels_taken, settings_used);
        $display("events: on %0d, off %0d, raise %0d, retrigger pairs %0d; errors %0d",
                 tracker.kinds_seen[nod_pkg::EV_ON], tracker.kinds_seen[nod_pkg::EV_OFF],
                 tracker.kinds_seen[nod_pkg::EV_RAISE], tracker.retriggers, tracker.errors);
        if (tracker.errors == 0 && tracker.pending.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

### files.f
rtl/nod_pkg.sv
rtl/nod_ram.sv
rtl/note_onoff_detector_core.sv
tb/note_onoff_detector_core_tb.sv
